// ----- hw/rtl/ptds_pkg.sv -----
// Package for the periodic task deadline scheduler.
// Holds sizing defaults, command and status codes. No dependencies.
package ptds_pkg;
    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam int PER_BITS      = 41;
    localparam int PRIO_BITS     = 8;
    localparam int CMD_BITS      = 2;
    localparam int STAT_BITS     = 3;
    localparam int SLOT_OUT_BITS = 4;
    localparam int MISS_BITS     = 32;
    localparam int NEXT_BITS     = 48;

    localparam logic [CMD_BITS-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_DISPATCH = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_COMPLETE = 2'd2;

    localparam logic [STAT_BITS-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL    = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_NONE    = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_RUNNING = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_IDLE    = 3'd4;
endpackage

// ----- hw/rtl/ptds_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module ptds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- hw/rtl/ptds_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module ptds_divider #(
    parameter int W = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W-1:0]  r_q, r_r, r_d;
    logic [W:0]    w_sh, w_sub;

    assign w_sh  = {r_r, r_q[W-1]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            // done follows the last quotient bit
            o_done <= r_busy && !i_start && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // shift-subtract datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_busy) begin
            if (!w_sub[W]) begin
                r_r <= w_sub[W-1:0];
                r_q <= {r_q[W-2:0], 1'b1};
            end else begin
                r_r <= w_sh[W-1:0];
                r_q <= {r_q[W-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_q;
    assign o_rem = r_r;
endmodule

// ----- hw/rtl/periodic_task_deadline_scheduler_unit.sv -----
// Periodic task deadline scheduler, top level.
// Throughput: one request at a time; busy is high until the result strobe.
// The slot scans and the serial divider set how long a request takes.
// Reset (synchronous, active low) clears valid/done marks, running state and pass time.
// Results show for one cycle on o_valid; the receiver cannot stall.
module periodic_task_deadline_scheduler_unit #(
    parameter int SLOTS     = ptds_pkg::SLOTS_DEF,
    parameter int TIME_BITS = ptds_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ptds_pkg::CMD_BITS-1:0]  i_cmd,
    input  logic [TIME_BITS-1:0]           i_time_value,
    input  logic signed [ptds_pkg::PER_BITS-1:0] i_period_us,
    input  logic [ptds_pkg::PRIO_BITS-1:0] i_priority_req,
    input  logic                           i_start_now,
    input  logic                           i_new_pass,
    input  logic                           i_has_new_period,
    output logic                           o_valid,
    output logic [ptds_pkg::STAT_BITS-1:0] o_status,
    output logic [$clog2(SLOTS)-1:0]       o_task_slot,
    output logic                           o_task_retired,
    output logic [TIME_BITS-1:0]           o_next_due,
    output logic [ptds_pkg::MISS_BITS-1:0] o_missed_periods
);
    import ptds_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = TIME_BITS;
    localparam logic [TW-1:0] TMAX = '1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADDSC = 4'd1;
    localparam logic [3:0] S_ADDWR = 4'd2;
    localparam logic [3:0] S_DRD   = 4'd3;
    localparam logic [3:0] S_DCMP  = 4'd4;
    localparam logic [3:0] S_DFIN  = 4'd5;
    localparam logic [3:0] S_CRD   = 4'd6;
    localparam logic [3:0] S_CWT   = 4'd7;
    localparam logic [3:0] S_CADD  = 4'd8;
    localparam logic [3:0] S_CDIV  = 4'd9;
    localparam logic [3:0] S_CFIX  = 4'd10;
    localparam logic [3:0] S_CWR   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]  r_state;
    logic [SLOTS-1:0] r_valid, r_done;
    logic        r_run;
    logic [SW-1:0] r_rslot;
    logic [TW-1:0] r_pass;

    // latched request
    logic [TW-1:0]  r_tv;
    logic [PER_BITS-1:0] r_per;
    logic [PRIO_BITS-1:0] r_prio;
    logic r_snow, r_hnp;

    logic [CW-1:0] r_idx;
    logic [SW-1:0] r_best;
    logic          r_found;
    logic [TW-1:0] r_bdue;
    logic [PRIO_BITS-1:0] r_bprio;
    logic [TW-1:0] r_nd, r_lag;
    logic [PER_BITS-1:0] r_p;
    logic [TW:0]  r_sum;

    logic [STAT_BITS-1:0] r_st;
    logic [SW-1:0] r_oslot;
    logic r_ret;
    logic [MISS_BITS-1:0] r_miss;

    // RAM ports
    logic          w_we;
    logic [SW-1:0] w_addr;
    logic [TW-1:0] w_due_wd, w_due_rd;
    logic [PER_BITS-1:0] w_per_wd, w_per_rd;
    logic [PRIO_BITS-1:0] w_pri_wd, w_pri_rd;
    logic w_pwe, w_pri_we;

    ptds_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_due (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_due_wd), .o_rdata(w_due_rd));
    ptds_ram #(.WIDTH(PER_BITS), .DEPTH(SLOTS)) u_per (
        .i_clk(i_clk), .i_we(w_pwe), .i_addr(w_addr), .i_wdata(w_per_wd), .o_rdata(w_per_rd));
    ptds_ram #(.WIDTH(PRIO_BITS), .DEPTH(SLOTS)) u_pri (
        .i_clk(i_clk), .i_we(w_pri_we), .i_addr(w_addr), .i_wdata(w_pri_wd),
        .o_rdata(w_pri_rd));

    // divider for catch-up
    logic          r_dstart;
    logic          w_ddone;
    logic [TW-1:0] w_quo, w_rem, w_den;
    assign w_den = TW'(r_p);
    ptds_divider #(.W(TW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart), .i_num(r_lag),
        .i_den(w_den), .o_done(w_ddone), .o_quo(w_quo), .o_rem(w_rem));

    logic [SW-1:0] w_idx;
    logic [SW-1:0] w_prev;
    assign w_idx  = r_idx[SW-1:0];
    assign w_prev = SW'(r_idx - 1'b1);

    // saturated due time plus period, and the late check
    logic [TW:0]   w_sum0;
    logic [TW-1:0] w_nd_sat;
    logic          w_late;
    assign w_sum0   = {1'b0, r_nd} + {1'b0, TW'(r_p)};
    assign w_nd_sat = w_sum0[TW] ? TMAX : w_sum0[TW-1:0];
    assign w_late   = !r_p[PER_BITS-1] && (r_p != '0) && (w_nd_sat < r_pass);

    // RAM address/write control
    always_comb begin
        w_we     = 1'b0;
        w_pwe    = 1'b0;
        w_pri_we = 1'b0;
        w_addr   = w_idx;
        w_due_wd = r_snow ? r_pass : r_tv;
        w_per_wd = r_per;
        w_pri_wd = r_prio;
        case (r_state)
            S_ADDWR: begin
                w_we = 1'b1; w_pwe = 1'b1; w_pri_we = 1'b1;
            end
            S_CRD, S_CWT: w_addr = r_rslot;
            S_CWR: begin
                w_addr   = r_rslot;
                w_we     = !r_p[PER_BITS-1];
                w_due_wd = r_nd;
                w_pwe    = r_hnp;
            end
            default: ;
        endcase
    end

    logic w_cand;
    assign w_cand = r_valid[w_prev] && !r_done[w_prev] && (w_due_rd <= r_tv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_done   <= '0;
            r_run    <= 1'b0;
            r_rslot  <= '0;
            r_pass   <= '0;
            r_dstart <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_dstart <= (r_state == S_CADD) && w_late;
            o_valid  <= (r_state == S_OUT);
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_tv <= TW'(i_time_value); r_per <= i_period_us;
                        r_prio <= i_priority_req; r_snow <= i_start_now;
                        r_hnp <= i_has_new_period;
                        r_idx <= '0; r_found <= 1'b0;
                        r_st <= ST_OK; r_oslot <= '0; r_ret <= 1'b0;
                        r_nd <= '0; r_miss <= '0;
                        case (i_cmd)
                            CMD_ADD: r_state <= S_ADDSC;
                            CMD_DISPATCH: begin
                                if (i_new_pass) r_done <= '0;
                                r_pass <= TW'(i_time_value);
                                if (r_run) begin
                                    r_st <= ST_RUNNING; r_state <= S_OUT;
                                end else begin
                                    r_state <= S_DRD;
                                end
                            end
                            CMD_COMPLETE: begin
                                if (!r_run) begin
                                    r_st <= ST_IDLE; r_state <= S_OUT;
                                end else begin
                                    r_state <= S_CRD;
                                end
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                // lowest free slot search
                S_ADDSC: begin
                    if (r_idx == CW'(SLOTS)) begin
                        r_st <= ST_FULL; r_state <= S_OUT;
                    end else if (!r_valid[w_idx]) begin
                        r_state <= S_ADDWR;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_ADDWR: begin
                    r_valid[w_idx] <= 1'b1;
                    r_done[w_idx]  <= 1'b0;
                    r_oslot <= w_idx;
                    r_state <= S_OUT;
                end
                // dispatch scan: issue read, compare next cycle
                S_DRD: begin
                    r_idx <= r_idx + 1'b1;
                    r_state <= S_DCMP;
                end
                S_DCMP: begin
                    if (w_cand && (!r_found || w_due_rd < r_bdue ||
                        (w_due_rd == r_bdue && w_pri_rd < r_bprio))) begin
                        r_found <= 1'b1; r_best <= w_prev;
                        r_bdue <= w_due_rd; r_bprio <= w_pri_rd;
                    end
                    r_state <= (r_idx == CW'(SLOTS)) ? S_DFIN : S_DRD;
                end
                S_DFIN: begin
                    if (r_found) begin
                        r_run <= 1'b1; r_rslot <= r_best; r_oslot <= r_best;
                    end else begin
                        r_st <= ST_NONE;
                    end
                    r_state <= S_OUT;
                end
                // complete
                S_CRD: r_state <= S_CWT;
                S_CWT: begin
                    r_p <= r_hnp ? r_per : w_per_rd;
                    r_nd <= w_due_rd;
                    r_oslot <= r_rslot;
                    r_run <= 1'b0;
                    r_state <= S_CADD;
                end
                S_CADD: begin
                    if (r_p[PER_BITS-1]) begin
                        r_valid[r_rslot] <= 1'b0;
                        r_done[r_rslot]  <= 1'b0;
                        r_ret <= 1'b1;
                        r_nd  <= '0;
                        r_state <= S_CWR;
                    end else begin
                        r_done[r_rslot] <= 1'b1;
                        if (w_late) begin
                            r_lag <= r_pass - w_nd_sat;
                            r_state <= S_CDIV;
                        end else begin
                            r_nd <= w_nd_sat;
                            r_state <= S_CWR;
                        end
                    end
                end
                S_CDIV: begin
                    if (w_ddone) begin
                        r_miss <= (w_quo >= TW'(64'hFFFF_FFFF)) ? '1
                                  : MISS_BITS'(w_quo + 1'b1);
                        r_sum <= {1'b0, r_pass} + {1'b0, TW'(r_p) - w_rem};
                        r_state <= S_CFIX;
                    end
                end
                S_CFIX: begin
                    r_nd <= r_sum[TW] ? TMAX : r_sum[TW-1:0];
                    r_state <= S_CWR;
                end
                S_CWR: r_state <= S_OUT;
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_status         = r_st;
    assign o_task_slot      = r_oslot;
    assign o_task_retired   = r_ret;
    assign o_next_due       = r_nd;
    assign o_missed_periods = r_miss;
endmodule

// ----- verif/tb_top.sv -----
// Testbench for the periodic task deadline scheduler: directed and random requests.
// Uses an in-bench predictor and a strobe-driven checker. Depends on ptds_pkg and the unit.
`timescale 1ns / 1ps

module tb_top;
    import ptds_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int NSLOT = 16;
    localparam logic [47:0] TIME_TOP = 48'hFFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [CMD_BITS-1:0]  cmd;
        logic [47:0]          time_value;
        logic [PER_BITS-1:0]  period;
        logic [PRIO_BITS-1:0] prio;
        logic                 start_now;
        logic                 new_pass;
        logic                 has_new;
    } t_sched_req;

    typedef struct packed {
        logic [STAT_BITS-1:0]     status;
        logic [SLOT_OUT_BITS-1:0] slot;
        logic                     retired;
        logic [NEXT_BITS-1:0]     next_due;
        logic [MISS_BITS-1:0]     missed;
    } t_sched_res;

    logic i_clk, i_rst_n, start, busy;
    logic [CMD_BITS-1:0] i_cmd;
    logic [47:0] i_time_value;
    logic signed [PER_BITS-1:0] i_period_us;
    logic [PRIO_BITS-1:0] i_priority_req;
    logic i_start_now, i_new_pass, i_has_new_period;
    logic o_valid, o_task_retired;
    logic [STAT_BITS-1:0] o_status;
    logic [SLOT_OUT_BITS-1:0] o_task_slot;
    logic [NEXT_BITS-1:0] o_next_due;
    logic [MISS_BITS-1:0] o_missed_periods;

    periodic_task_deadline_scheduler_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_time_value(i_time_value), .i_period_us(i_period_us),
        .i_priority_req(i_priority_req), .i_start_now(i_start_now),
        .i_new_pass(i_new_pass), .i_has_new_period(i_has_new_period),
        .o_valid(o_valid), .o_status(o_status), .o_task_slot(o_task_slot),
        .o_task_retired(o_task_retired), .o_next_due(o_next_due),
        .o_missed_periods(o_missed_periods)
    );

    // Clock, 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Shadow of the task table
    logic                 tbl_valid [NSLOT];
    logic [47:0]          tbl_due   [NSLOT];
    logic [PER_BITS-1:0]  tbl_per   [NSLOT];
    logic [PRIO_BITS-1:0] tbl_prio  [NSLOT];
    logic                 tbl_done  [NSLOT];
    logic                 run_active;
    int                   run_slot;
    logic [47:0]          pass_stamp;

    t_sched_res due_results[$];
    bit         failed;
    int         idle_pct;
    longint     cycle_cnt;
    logic [47:0] now_us;

    function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > TIME_TOP) ? {16'd0, TIME_TOP} : s;
    endfunction

    // Predict one result and advance the shadow table
    function automatic t_sched_res schedule_predict(t_sched_req r);
        t_sched_res   res;
        int           best;
        int           s;
        logic [63:0]  p, nd, lag, n;
        res = '0;
        best = NSLOT;
        case (r.cmd)
            CMD_ADD: begin
                for (int i = 0; i < NSLOT; i++)
                    if (!tbl_valid[i] && best == NSLOT) best = i;
                if (best == NSLOT) begin
                    res.status = ST_FULL;
                end else begin
                    tbl_valid[best] = 1'b1;
                    tbl_due[best]   = r.start_now ? pass_stamp : r.time_value;
                    tbl_per[best]   = r.period;
                    tbl_prio[best]  = r.prio;
                    tbl_done[best]  = 1'b0;
                    res.slot = SLOT_OUT_BITS'(best);
                end
            end
            CMD_DISPATCH: begin
                if (r.new_pass)
                    for (int i = 0; i < NSLOT; i++) tbl_done[i] = 1'b0;
                pass_stamp = r.time_value;
                if (run_active) begin
                    res.status = ST_RUNNING;
                end else begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!tbl_valid[i] || tbl_done[i] || tbl_due[i] > r.time_value)
                            continue;
                        if (best == NSLOT || tbl_due[i] < tbl_due[best] ||
                            (tbl_due[i] == tbl_due[best] && tbl_prio[i] < tbl_prio[best]))
                            best = i;
                    end
                    if (best == NSLOT) begin
                        res.status = ST_NONE;
                    end else begin
                        run_active = 1'b1;
                        run_slot = best;
                        res.slot = SLOT_OUT_BITS'(best);
                    end
                end
            end
            CMD_COMPLETE: begin
                if (!run_active) begin
                    res.status = ST_IDLE;
                end else begin
                    s = run_slot;
                    res.slot = SLOT_OUT_BITS'(s);
                    run_active = 1'b0;
                    if (r.has_new) tbl_per[s] = r.period;
                    if (tbl_per[s][PER_BITS-1]) begin
                        // one-shot: free the slot
                        tbl_valid[s] = 1'b0;
                        tbl_done[s] = 1'b0;
                        res.retired = 1'b1;
                    end else begin
                        p  = {23'd0, tbl_per[s]};
                        nd = clamp_add({16'd0, tbl_due[s]}, p);
                        if (p != 0 && nd < {16'd0, pass_stamp}) begin
                            // fell behind: skip whole periods
                            lag = {16'd0, pass_stamp} - nd;
                            n = lag / p + 1;
                            res.missed = (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
                            nd = clamp_add({16'd0, pass_stamp}, p - lag % p);
                        end
                        tbl_due[s] = nd[47:0];
                        tbl_done[s] = 1'b1;
                        res.next_due = nd[47:0];
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Drive one request and hold it until the unit is no longer busy
    task automatic send_request(t_sched_req r);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_cmd            <= r.cmd;
        i_time_value     <= r.time_value;
        i_period_us      <= r.period;
        i_priority_req   <= r.prio;
        i_start_now      <= r.start_now;
        i_new_pass       <= r.new_pass;
        i_has_new_period <= r.has_new;
        do @(posedge i_clk); while (busy);
        due_results.insert(due_results.size(), schedule_predict(r));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_sched_req mk(logic [CMD_BITS-1:0] c, logic [47:0] t,
                                      logic [PER_BITS-1:0] p, logic [7:0] pr,
                                      logic sn, logic np, logic hn);
        t_sched_req r;
        r.cmd = c; r.time_value = t; r.period = p; r.prio = pr;
        r.start_now = sn; r.new_pass = np; r.has_new = hn;
        return r;
    endfunction

    // Every command, the idle, none and running statuses, and the tie-break
    task automatic test_commands();
        send_request(mk(CMD_COMPLETE, 0, 0, 0, 0, 0, 0));          // none running
        send_request(mk(CMD_DISPATCH, 10, 0, 0, 0, 0, 0));         // nothing due
        send_request(mk(CMD_ADD, 5, 41'd100, 8'd255, 0, 0, 0));
        send_request(mk(CMD_ADD, 5, 41'd50, 8'd0, 0, 0, 0));       // wins on rank
        send_request(mk(CMD_ADD, 0, '1, 8'd0, 1, 0, 0));           // start at pass time
        send_request(mk(CMD_DISPATCH, 20, 0, 0, 0, 0, 0));
        send_request(mk(CMD_DISPATCH, 20, 0, 0, 0, 1, 0));         // already running
        send_request(mk(CMD_COMPLETE, 0, 41'd0, 0, 0, 0, 1));      // zero period
        send_request(mk(CMD_DISPATCH, 20, 0, 0, 0, 0, 0));         // done mark skips it
        send_request(mk(CMD_COMPLETE, 0, {1'b1, 40'd0}, 0, 0, 0, 1)); // retire
        send_request(mk(CMD_UNUSED, TIME_TOP, '1, 8'hFF, 1, 1, 1));
        send_request(mk(CMD_DISPATCH, 500, 0, 0, 0, 1, 0));
        send_request(mk(CMD_COMPLETE, 0, 0, 0, 0, 0, 0));          // zero period: no catch-up
    endtask

    // Due time and catch-up count saturation
    task automatic test_saturation();
        wait_drained();
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i]) begin
                send_request(mk(CMD_DISPATCH, TIME_TOP, 0, 0, 0, 1, 0));
                send_request(mk(CMD_COMPLETE, 0, '1, 0, 0, 0, 1));
            end
        send_request(mk(CMD_ADD, 0, 41'd1, 8'd3, 0, 0, 0));
        send_request(mk(CMD_DISPATCH, 48'h8000_0000_0000, 0, 0, 0, 1, 0));
        send_request(mk(CMD_COMPLETE, 0, 0, 0, 0, 0, 0));
        send_request(mk(CMD_ADD, TIME_TOP - 5, {1'b0, {40{1'b1}}}, 8'd1, 0, 0, 0));
        send_request(mk(CMD_DISPATCH, TIME_TOP, 0, 0, 0, 1, 0));
        send_request(mk(CMD_COMPLETE, 0, 0, 0, 0, 0, 0));
    endtask

    // Send one add more than there are slots, so that the table fills and later adds see it full
    task automatic test_table_full();
        for (int i = 0; i <= NSLOT; i++)
            send_request(mk(CMD_ADD, 48'($urandom_range(0, 200)),
                            PER_BITS'($urandom_range(0, 90)),
                            8'($urandom_range(0, 3)), 0, 0, 0));
    endtask

    task automatic test_random(int count, int pct);
        t_sched_req r;
        int k;
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            r = mk(CMD_UNUSED, 48'({$urandom, $urandom}), PER_BITS'({$urandom, $urandom}),
                   8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            now_us += 48'($urandom_range(0, 40));
            if (k < 30) begin
                r.cmd = CMD_ADD;
                if ($urandom_range(9) != 0)
                    r.time_value = now_us + 48'($urandom_range(0, 60));
                case ($urandom_range(9))
                    0, 1, 2: r.period = '1;
                    3:       r.period = 0;
                    4:       ;
                    default: r.period = PER_BITS'($urandom_range(1, 120));
                endcase
            end else if (k < 65) begin
                r.cmd = CMD_DISPATCH;
                if ($urandom_range(19) != 0) r.time_value = now_us;
                r.new_pass = ($urandom_range(3) == 0);
            end else if (k < 96) begin
                r.cmd = CMD_COMPLETE;
                r.has_new = ($urandom_range(2) == 0);
                if ($urandom_range(3) != 0)
                    r.period = ($urandom_range(1) != 0) ? '1
                               : PER_BITS'($urandom_range(0, 100));
            end
            send_request(r);
        end
        wait_drained();
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_sched_res e;
        if (i_rst_n && o_valid) begin
            if (due_results.size() == 0) begin
                $error("unexpected result, status %0d", o_status);
                failed = 1'b1;
            end else begin
                e = due_results.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); failed = 1'b1;
                end
                if (o_task_slot !== e.slot) begin
                    $error("task_slot exp %0d got %0d", e.slot, o_task_slot); failed = 1'b1;
                end
                if (o_task_retired !== e.retired) begin
                    $error("task_retired exp %0d got %0d", e.retired, o_task_retired);
                    failed = 1'b1;
                end
                if (o_next_due !== e.next_due) begin
                    $error("next_due exp %0h got %0h", e.next_due, o_next_due); failed = 1'b1;
                end
                if (o_missed_periods !== e.missed) begin
                    $error("missed_periods exp %0h got %0h", e.missed, o_missed_periods);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        cycle_cnt = 0;
        failed = 1'b0;
        idle_pct = 0;
        now_us = 0;
        run_active = 1'b0;
        run_slot = 0;
        pass_stamp = '0;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 1'b0; tbl_done[i] = 1'b0;
            tbl_due[i] = '0; tbl_per[i] = '0; tbl_prio[i] = '0;
        end
        i_rst_n = 1'b0; start = 1'b0; i_cmd = CMD_ADD; i_time_value = '0;
        i_period_us = '0; i_priority_req = '0; i_start_now = 1'b0;
        i_new_pass = 1'b0; i_has_new_period = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_commands();
        test_saturation();
        test_table_full();
        test_random(160, 0);
        test_random(170, 46);
        test_random(160, 0);
        test_random(160, 36);

        repeat (150) @(posedge i_clk);
        if (!failed && due_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
